@@ rtl/utf8d_pkg.sv @@
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned CntW  = 2;

  // lead byte patterns
  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [2:0]       Lead2Tag   = 3'b110;
  localparam logic [3:0]       Lead3Tag   = 4'b1110;
  localparam logic [4:0]       Lead4Tag   = 5'b11110;
  localparam logic [ByteW-1:0] SurrLead   = 8'hed;
  localparam logic [ByteW-1:0] SurrMask   = 8'ha0;

  typedef struct packed {
    logic [CntW-1:0]  bytes_left;
    logic [CntW-1:0]  bytes_seen;
    logic [CodeW-1:0] partial_code;
    logic             lead_was_ed;
  } seq_state_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             bad_sequence;
    logic             out_last;
  } result_t;

  localparam seq_state_t SeqIdle = '{
    bytes_left:   '0,
    bytes_seen:   '0,
    partial_code: '0,
    lead_was_ed:  1'b0
  };

endpackage

@@ rtl/utf8_stream_decoder_top.sv @@
`timescale 1ns / 1ps

// utf8 stream decoder
// input channel: one text byte per transaction (in_byte_i, end_of_text_i),
//   handshake in_valid_i / in_ready_o
// output channel: one decoded code point or error per transaction
//   (code_point_o, bad_sequence_o, out_last_o), handshake out_valid_o / out_ready_i
// a byte that leaves a multi-byte sequence open gives no output transaction;
//   the byte that completes it, or a byte flagged end_of_text, gives exactly one
// a result is registered in the output register, or in the skid register behind it
// throughput: one byte per cycle while in_ready_o is high, set by the single
//   decode step between the sequence state register and the output register
// a two-entry output (main register plus skid register) keeps in_ready_o high
//   for one extra result while the receiver stalls; in_ready_o drops only when
//   both entries hold results
// reset clears the sequence state and both output entries; no transaction is
//   lost or repeated under any pattern of valid and ready on either side
module utf8_stream_decoder_top import utf8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CodeW-1:0] code_point_o,
  output logic             bad_sequence_o,
  output logic             out_last_o
);

  seq_state_t state_q, state_d, step_state;
  logic       step_emit;
  result_t    step_res;

  result_t    out_q, out_d, skid_q, skid_d;
  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic       accept, push, pop;

  // combinational decode of one byte against the pending sequence
  utf8d_step u_step (
    .state_i       (state_q),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .state_o       (step_state),
    .emit_o        (step_emit),
    .result_o      (step_res)
  );

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && step_emit;
  assign pop        = out_valid_q && out_ready_i;

  assign state_d = accept ? step_state : state_q;

  // output register with skid entry behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push;
        skid_d       = push ? step_res : skid_q;
      end else begin
        out_d       = step_res;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SeqIdle;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = out_q.code_point;
  assign bad_sequence_o = out_q.bad_sequence;
  assign out_last_o     = out_q.out_last;

endmodule

@@ rtl/utf8d_step.sv @@
`timescale 1ns / 1ps

module utf8d_step import utf8d_pkg::*; (
  input  seq_state_t       state_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_text_i,
  output seq_state_t       state_o,
  output logic             emit_o,
  output result_t          result_o
);

  seq_state_t       cont;
  logic             ed_next;
  logic             lead_open;

  always_comb begin
    state_o   = state_i;
    emit_o    = 1'b0;
    result_o  = '{code_point: '0, bad_sequence: 1'b0, out_last: end_of_text_i};
    lead_open = 1'b0;
    cont      = state_i;
    ed_next   = state_i.lead_was_ed;

    if (state_i.bytes_left == '0) begin
      if (in_byte_i < AsciiLimit) begin
        emit_o              = 1'b1;
        result_o.code_point = CodeW'(in_byte_i);
      end else if (in_byte_i[7:5] == Lead2Tag) begin
        lead_open             = 1'b1;
        state_o.partial_code  = CodeW'(in_byte_i[4:0]);
        state_o.bytes_left    = CntW'(1);
        state_o.bytes_seen    = CntW'(1);
      end else if (in_byte_i[7:4] == Lead3Tag) begin
        lead_open             = 1'b1;
        state_o.partial_code  = CodeW'(in_byte_i[3:0]);
        state_o.bytes_left    = CntW'(2);
        state_o.bytes_seen    = CntW'(1);
        state_o.lead_was_ed   = (in_byte_i == SurrLead);
      end else if (in_byte_i[7:3] == Lead4Tag) begin
        lead_open             = 1'b1;
        state_o.partial_code  = CodeW'(in_byte_i[2:0]);
        state_o.bytes_left    = CntW'(3);
        state_o.bytes_seen    = CntW'(1);
      end else begin
        // stray continuation or illegal lead
        state_o               = SeqIdle;
        emit_o                = 1'b1;
        result_o.bad_sequence = 1'b1;
      end
      // text ends right after a multi-byte lead
      if (lead_open && end_of_text_i) begin
        state_o               = SeqIdle;
        emit_o                = 1'b1;
        result_o.bad_sequence = 1'b1;
      end
    end else begin
      // surrogate check only on the byte after an 0xed lead
      if (state_i.bytes_seen == CntW'(1) && state_i.lead_was_ed &&
          (in_byte_i & SurrMask) != SurrMask) begin
        ed_next = 1'b0;
      end
      cont.lead_was_ed  = ed_next;
      cont.partial_code = {state_i.partial_code[CodeW-7:0], in_byte_i[5:0]};
      cont.bytes_left   = state_i.bytes_left - CntW'(1);
      cont.bytes_seen   = state_i.bytes_seen + CntW'(1);
      if (cont.bytes_left == '0) begin
        state_o               = SeqIdle;
        emit_o                = 1'b1;
        result_o.bad_sequence = ed_next;
        result_o.code_point   = ed_next ? '0 : cont.partial_code;
      end else if (end_of_text_i) begin
        state_o               = SeqIdle;
        emit_o                = 1'b1;
        result_o.bad_sequence = 1'b1;
      end else begin
        state_o = cont;
      end
    end
  end

endmodule
